/* rtl/core/chd_pkg.sv */
// shared constants, types and tables for the compass heading block
`default_nettype none

package chd_pkg;

  // field widths
  localparam int RAW_W    = 16;
  localparam int AXIS_W   = 16;
  localparam int ADJ_W    = 8;
  localparam int DECL_W   = 15;
  localparam int DEG_W    = 9;
  localparam int SECTOR_W = 3;

  // apb port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // reset values of the configuration registers
  localparam int ADJ_RESET  = 128;
  localparam int DECL_RESET = 577;

  // sensitivity scaling
  localparam int GAIN_OFS = 128;
  localparam int GAIN_W   = ADJ_W + 2;
  localparam int NEG_W    = RAW_W + 1;
  localparam int PROD_W   = NEG_W + GAIN_W;
  localparam int SCL_W    = AXIS_W + 3;
  localparam int AXIS_MAX = 2 ** (AXIS_W - 1) - 1;
  localparam int AXIS_MIN = -(2 ** (AXIS_W - 1));

  // ring of centred pairs
  localparam int ENTRY_W    = AXIS_W + 1;
  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int SUM_W      = ENTRY_W + SLOT_W;
  localparam int MEAN_W     = ENTRY_W;

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int PRE_SHIFT    = 8;
  localparam int VEC_W        = MEAN_W + PRE_SHIFT + 3;
  localparam int ANG_W        = 21;
  localparam int ATAN_IDX_W   = 5;
  localparam int ATAN_W       = 17;
  localparam int PI_Q16       = 205887;
  localparam int TURN_Q16     = 2 * PI_Q16;
  localparam logic signed [ANG_W-1:0] PI_ANG = ANG_W'(PI_Q16);

  // angle post processing
  localparam int DECL_SHIFT  = 4;
  localparam int WRAP_W      = ANG_W + 1;
  localparam int CAND_W      = WRAP_W + 1;
  localparam int ANGU_W      = 19;
  localparam int DEG_HALF    = 180;
  localparam int DEG_FULL    = 360;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 32;
  localparam int PRODR_W     = ANGU_W + RECIP_W;
  localparam int MUL_W       = 27;
  localparam logic [RECIP_W-1:0] RECIP_Q32 =
    RECIP_W'((longint'(DEG_HALF) << RECIP_SHIFT) / longint'(PI_Q16));
  localparam logic signed [CAND_W-1:0] TURN_C  = CAND_W'(TURN_Q16);
  localparam logic signed [CAND_W-1:0] TURN2_C = CAND_W'(2 * TURN_Q16);

  // sectors
  localparam int SECTOR_LO   = 22;
  localparam int SECTOR_WRAP = 337;
  localparam int SECTOR_BAND = 45;
  localparam int SECTOR_N    = 7;

  typedef enum logic [1:0] {
    REG_SENS_X = 2'd0,
    REG_SENS_Y = 2'd1,
    REG_DECL   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_DONE
  } cs_t;

  // atan(2^-i) in q16 radians, rounded to nearest
  function automatic logic [ATAN_W-1:0] chd_atan(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30386;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/chd_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none

module chd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/chd_cordic.sv */
// iterative vectoring cordic giving atan2 of the ring means in q16 radians
`default_nettype none

module chd_cordic
  import chd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start_valid,
  output logic                          start_ready,
  input  wire logic signed [MEAN_W-1:0] mean_x,
  input  wire logic signed [MEAN_W-1:0] mean_y,
  output logic                          z_valid,
  input  wire logic                     z_ready,
  output logic signed [ANG_W-1:0]       z
);

  cs_t                     state_r, state_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic                    load;
  logic signed [VEC_W-1:0] vx_r, vy_r, vx_nxt, vy_nxt;
  logic signed [VEC_W-1:0] mx_ext, my_ext, dx, dy;
  logic signed [ANG_W-1:0] z_r, z_nxt, step_ang;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    start_ready = 1'b0;
    z_valid     = 1'b0;
    case (state_r)
      CS_IDLE: begin
        start_ready = 1'b1;
      end
      CS_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = CS_DONE;
        end
      end
      CS_DONE: begin
        z_valid     = 1'b1;
        start_ready = z_ready;
        if (z_ready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
    if (start_ready && start_valid) begin
      state_nxt = CS_RUN;
      cnt_nxt   = '0;
    end
  end

  assign load = start_ready && start_valid;

  // means scaled by 256 before rotation
  assign mx_ext   = VEC_W'(mean_x) <<< PRE_SHIFT;
  assign my_ext   = VEC_W'(mean_y) <<< PRE_SHIFT;
  assign dx       = vy_r >>> cnt_r;
  assign dy       = vx_r >>> cnt_r;
  assign step_ang = ANG_W'(chd_atan(ATAN_IDX_W'(cnt_r)));

  always_comb begin
    vx_nxt = vx_r;
    vy_nxt = vy_r;
    z_nxt  = z_r;
    if (load) begin
      if (mean_x < 0) begin
        // left half plane: turn by pi first
        vx_nxt = -mx_ext;
        vy_nxt = -my_ext;
        z_nxt  = (mean_y >= 0) ? PI_ANG : -PI_ANG;
      end else begin
        vx_nxt = mx_ext;
        vy_nxt = my_ext;
        z_nxt  = '0;
      end
    end else if (state_r == CS_RUN) begin
      if (vy_r > 0) begin
        vx_nxt = vx_r + dx;
        vy_nxt = vy_r - dy;
        z_nxt  = z_r + step_ang;
      end else begin
        vx_nxt = vx_r - dx;
        vy_nxt = vy_r + dy;
        z_nxt  = z_r - step_ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    vx_r <= vx_nxt;
    vy_r <= vy_nxt;
    z_r  <= z_nxt;
  end

  assign z = z_r;

endmodule

`default_nettype wire

/* rtl/core/compass_heading_hard_iron_avg_top.sv */
// compass heading: sensitivity scaling, hard-iron centring, ring mean, atan2, sector
// the 16-step cordic takes new means only when idle or as its last result is taken
// the front end accepts beats while the cordic works until the pending slot fills; flagged beats give no result
// reset (sync, active low): registers to defaults, min/max to extremes, ring valid bits cleared
// the ring ram itself is never swept: unwritten entries read as zero through the valid bits
`default_nettype none

module compass_heading_hard_iron_avg_top
  import chd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [PADDR_W-1:0]      paddr,
  input  wire logic [PDATA_W-1:0]      pwdata,
  output logic      [PDATA_W-1:0]      prdata,
  output logic                         pready,
  // sample channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [RAW_W-1:0] in_raw_x,
  input  wire logic signed [RAW_W-1:0] in_raw_y,
  input  wire logic                    in_data_overrun,
  input  wire logic                    in_sensor_overflow,
  // heading channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [DEG_W-1:0]        out_heading_deg,
  output logic      [SECTOR_W-1:0]     out_sector
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [ADJ_W-1:0]         sens_x_r, sens_y_r;
  logic signed [DECL_W-1:0] decl_r;
  reg_idx_t                 cfg_idx;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_x_r <= ADJ_W'(ADJ_RESET);
      sens_y_r <= ADJ_W'(ADJ_RESET);
      decl_r   <= DECL_W'(DECL_RESET);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SENS_X: sens_x_r <= pwdata[ADJ_W-1:0];
        REG_SENS_Y: sens_y_r <= pwdata[ADJ_W-1:0];
        REG_DECL:   decl_r   <= pwdata[DECL_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SENS_X: prdata = PDATA_W'(sens_x_r);
      REG_SENS_Y: prdata = PDATA_W'(sens_y_r);
      REG_DECL:   prdata = PDATA_W'(decl_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front end: five stages moving together on adv
  //   s0 raw sample, s1 gain product, s2 scaled axis, s3 min/max sum, s4 ring entry
  //   then the pending slot that feeds the cordic
  // ---------------------------------------------------------------------------
  logic adv;
  logic cdc_start_ready;

  logic v0_r, v1_r, v2_r, v3_r, v4_r, p_v_r;

  logic signed [RAW_W-1:0]   raw_x0_r, raw_y0_r;
  logic signed [PROD_W-1:0]  prod_x1_r, prod_y1_r;
  logic signed [AXIS_W-1:0]  sx2_r, sy2_r, sx3_r, sy3_r;
  logic signed [ENTRY_W-1:0] mm_x3_r, mm_y3_r;
  logic signed [ENTRY_W-1:0] e_x4_r, e_y4_r;
  logic [SLOT_W-1:0]         slot4_r;
  logic                      old_vld4_r;
  logic signed [SUM_W-1:0]   p_sx_r, p_sy_r;

  // running state
  logic signed [AXIS_W-1:0]  max_x_r, min_x_r, max_y_r, min_y_r;
  logic signed [SUM_W-1:0]   sum_x_r, sum_y_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [RING_DEPTH-1:0]     vld_r;

  // combinational helpers
  logic signed [NEG_W-1:0]   neg_x, neg_y;
  logic signed [GAIN_W-1:0]  gain_x, gain_y;
  logic signed [SCL_W-1:0]   q_x, q_y;
  logic signed [AXIS_W-1:0]  s_x, s_y;
  logic signed [AXIS_W-1:0]  nmax_x, nmin_x, nmax_y, nmin_y;
  logic signed [AXIS_W-1:0]  c_x, c_y;
  logic signed [ENTRY_W-1:0] old_x, old_y;
  logic signed [SUM_W-1:0]   sum_x_nxt, sum_y_nxt;
  logic [SLOT_W-1:0]         slot_nxt;

  // ring ram ports
  logic                      ram_we, ram_re;
  logic [SLOT_W-1:0]         ram_waddr, ram_raddr;
  logic [2*ENTRY_W-1:0]      ram_wdata, ram_rdata;

  // the whole front end stalls only while the pending slot waits on the cordic
  assign adv      = !p_v_r || cdc_start_ready;
  assign in_ready = adv;

  function automatic logic signed [AXIS_W-1:0] sat_axis(input logic signed [SCL_W-1:0] q);
    logic signed [AXIS_W-1:0] r;
    if (q > AXIS_MAX) begin
      r = AXIS_W'(AXIS_MAX);
    end else if (q < AXIS_MIN) begin
      r = AXIS_W'(AXIS_MIN);
    end else begin
      r = AXIS_W'(q);
    end
    return r;
  endfunction

  // s0 -> s1: negate and multiply by the sensitivity gain
  assign neg_x  = -(NEG_W'(raw_x0_r));
  assign neg_y  = -(NEG_W'(raw_y0_r));
  assign gain_x = GAIN_W'(sens_x_r) + GAIN_W'(GAIN_OFS);
  assign gain_y = GAIN_W'(sens_y_r) + GAIN_W'(GAIN_OFS);

  // s1 -> s2: divide by 256 toward zero, then saturate
  assign q_x = SCL_W'(prod_x1_r / 256);
  assign q_y = SCL_W'(prod_y1_r / 256);
  assign s_x = sat_axis(q_x);
  assign s_y = sat_axis(q_y);

  // s2 -> s3: running extremes
  assign nmax_x = (sx2_r > max_x_r) ? sx2_r : max_x_r;
  assign nmin_x = (sx2_r < min_x_r) ? sx2_r : min_x_r;
  assign nmax_y = (sy2_r > max_y_r) ? sy2_r : max_y_r;
  assign nmin_y = (sy2_r < min_y_r) ? sy2_r : min_y_r;

  // s3 -> s4: hard-iron centre, truncated toward zero
  assign c_x = AXIS_W'(mm_x3_r / 2);
  assign c_y = AXIS_W'(mm_y3_r / 2);

  assign slot_nxt = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  // s4: the slot's old pair arrives from the ram, never-written slots count as zero
  assign old_x     = old_vld4_r ? ram_rdata[2*ENTRY_W-1 -: ENTRY_W] : '0;
  assign old_y     = old_vld4_r ? ram_rdata[ENTRY_W-1:0] : '0;
  assign sum_x_nxt = sum_x_r + SUM_W'(e_x4_r) - SUM_W'(old_x);
  assign sum_y_nxt = sum_y_r + SUM_W'(e_y4_r) - SUM_W'(old_y);

  // read in s3 so the data lines up with s4; read enable follows adv to hold under stall
  assign ram_re    = adv;
  assign ram_raddr = slot_r;
  assign ram_we    = adv && v4_r;
  assign ram_waddr = slot4_r;
  assign ram_wdata = {e_x4_r, e_y4_r};

  chd_ram #(
    .WIDTH (2 * ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      p_v_r   <= 1'b0;
      max_x_r <= AXIS_W'(AXIS_MIN);
      min_x_r <= AXIS_W'(AXIS_MAX);
      max_y_r <= AXIS_W'(AXIS_MIN);
      min_y_r <= AXIS_W'(AXIS_MAX);
      sum_x_r <= '0;
      sum_y_r <= '0;
      slot_r  <= '0;
      vld_r   <= '0;
    end else if (adv) begin
      // flagged samples are taken and dropped here
      v0_r  <= in_valid && !in_data_overrun && !in_sensor_overflow;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      p_v_r <= v4_r;
      if (v2_r) begin
        max_x_r <= nmax_x;
        min_x_r <= nmin_x;
        max_y_r <= nmax_y;
        min_y_r <= nmin_y;
      end
      if (v3_r) begin
        slot_r <= slot_nxt;
      end
      if (v4_r) begin
        sum_x_r        <= sum_x_nxt;
        sum_y_r        <= sum_y_nxt;
        vld_r[slot4_r] <= 1'b1;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      raw_x0_r   <= in_raw_x;
      raw_y0_r   <= in_raw_y;
      prod_x1_r  <= PROD_W'(neg_x) * PROD_W'(gain_x);
      prod_y1_r  <= PROD_W'(neg_y) * PROD_W'(gain_y);
      sx2_r      <= s_x;
      sy2_r      <= s_y;
      sx3_r      <= sx2_r;
      sy3_r      <= sy2_r;
      mm_x3_r    <= ENTRY_W'(nmax_x) + ENTRY_W'(nmin_x);
      mm_y3_r    <= ENTRY_W'(nmax_y) + ENTRY_W'(nmin_y);
      e_x4_r     <= ENTRY_W'(sx3_r) - ENTRY_W'(c_x);
      e_y4_r     <= ENTRY_W'(sy3_r) - ENTRY_W'(c_y);
      slot4_r    <= slot_r;
      old_vld4_r <= vld_r[slot_r];
      p_sx_r     <= sum_x_nxt;
      p_sy_r     <= sum_y_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // cordic: ring means (truncated toward zero) to an angle
  // ---------------------------------------------------------------------------
  logic signed [MEAN_W-1:0] mean_x, mean_y;
  logic                     z_valid, z_ready;
  logic signed [ANG_W-1:0]  z_ang;

  assign mean_x = MEAN_W'(p_sx_r / RING_DEPTH);
  assign mean_y = MEAN_W'(p_sy_r / RING_DEPTH);

  chd_cordic u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_valid (p_v_r),
    .start_ready (cdc_start_ready),
    .mean_x      (mean_x),
    .mean_y      (mean_y),
    .z_valid     (z_valid),
    .z_ready     (z_ready),
    .z           (z_ang)
  );

  // ---------------------------------------------------------------------------
  // angle to degrees: four stages plus the output register, stalled by out_ready
  //   q0 minus declination, q1 wrap into one turn, q2 reciprocal product,
  //   q3 remainder terms, then one-step correction and sector into the output
  // ---------------------------------------------------------------------------
  logic pa;
  logic q0_v_r, q1_v_r, q2_v_r, q3_v_r, out_valid_r;

  logic signed [WRAP_W-1:0]  a1_r;
  logic [ANGU_W-1:0]         a2_r, a2c_r;
  logic [PRODR_W-1:0]        prod2_r;
  logic [DEG_W-1:0]          q3_r;
  logic [MUL_W-1:0]          qm3_r, a180_r;
  logic [DEG_W-1:0]          heading_r;
  logic [SECTOR_W-1:0]       sector_r;

  logic signed [WRAP_W-1:0]  a1_nxt;
  logic signed [CAND_W-1:0]  c_lo1, c_lo2, c_hi1, c_hi2, a_sel;
  logic [DEG_W-1:0]          q_est;
  logic [MUL_W-1:0]          rem;
  logic [DEG_W-1:0]          deg;
  logic [SECTOR_W-1:0]       sec;

  assign pa      = !out_valid_r || out_ready;
  assign z_ready = pa;

  // declination from q12 to q16
  assign a1_nxt = WRAP_W'(z_ang) - (WRAP_W'(decl_r) <<< DECL_SHIFT);

  assign c_lo1 = CAND_W'(a1_r) + TURN_C;
  assign c_lo2 = CAND_W'(a1_r) + TURN2_C;
  assign c_hi1 = CAND_W'(a1_r) - TURN_C;
  assign c_hi2 = CAND_W'(a1_r) - TURN2_C;

  always_comb begin
    if (a1_r < 0) begin
      a_sel = (c_lo1 < 0) ? c_lo2 : c_lo1;
    end else if (a1_r >= TURN_C) begin
      a_sel = (c_hi1 >= TURN_C) ? c_hi2 : c_hi1;
    end else begin
      a_sel = CAND_W'(a1_r);
    end
  end

  // estimate is exact or one low; the remainder settles it
  assign q_est = prod2_r[RECIP_SHIFT +: DEG_W];
  assign rem   = a180_r - qm3_r;
  assign deg   = q3_r + DEG_W'(rem >= MUL_W'(PI_Q16));

  always_comb begin
    sec = '0;
    if (!(deg >= DEG_W'(SECTOR_WRAP) || deg < DEG_W'(SECTOR_LO))) begin
      sec = SECTOR_W'(1);
      for (int k = 1; k < SECTOR_N; k++) begin
        if (deg >= DEG_W'(SECTOR_LO + k * SECTOR_BAND)) begin
          sec = sec + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_v_r      <= 1'b0;
      q1_v_r      <= 1'b0;
      q2_v_r      <= 1'b0;
      q3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pa) begin
      q0_v_r      <= z_valid;
      q1_v_r      <= q0_v_r;
      q2_v_r      <= q1_v_r;
      q3_v_r      <= q2_v_r;
      out_valid_r <= q3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pa) begin
      a1_r      <= a1_nxt;
      a2_r      <= ANGU_W'(a_sel);
      prod2_r   <= PRODR_W'(a2_r) * PRODR_W'(RECIP_Q32);
      a2c_r     <= a2_r;
      q3_r      <= q_est;
      qm3_r     <= MUL_W'(q_est) * MUL_W'(PI_Q16);
      a180_r    <= MUL_W'(a2c_r) * MUL_W'(DEG_HALF);
      heading_r <= deg;
      sector_r  <= sec;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_heading_deg = heading_r;
  assign out_sector      = sector_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading_deg < DEG_W'(DEG_FULL))
    else $error("heading outside one turn");

  a_sector_north: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_heading_deg >= DEG_W'(SECTOR_WRAP) || out_heading_deg < DEG_W'(SECTOR_LO))
    |-> out_sector == '0)
    else $error("north band not in sector zero");

  a_pending_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r && !cdc_start_ready |=> p_v_r && $stable(p_sx_r) && $stable(p_sy_r))
    else $error("pending means lost while cordic busy");

  a_ring_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ram_waddr != ram_raddr)
    else $error("ring read and write hit the same slot");

endmodule

`default_nettype wire

/* tb/tb_compass_heading_hard_iron_avg_top.sv */
// self-checking testbench for the compass heading block with hard-iron centring
module tb_compass_heading_hard_iron_avg_top
  import chd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // run sizing
  localparam int RANDOM_PER_SEG = 225;     // six segments, about 1350 random samples
  localparam int DRAIN_GAP      = 64;      // settle gap after the last heading is back
  localparam int CYCLE_LIMIT    = 500000;  // watchdog bound on the whole run

  // index past the last register, must be ignored by the block
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // declination extremes, +-pi in q12
  localparam int DECL_LIMIT = 12868;

  // arctan(2^-i) in q16 radians for the vectoring steps
  localparam int ARCTAN_Q16 [17] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  typedef struct {
    logic [DEG_W-1:0]    deg;
    logic [SECTOR_W-1:0] sector;
  } heading_t;

  // ---------------------------------------------------------------------------
  // scoreboard: mirrors the block's state and predicts one heading per clean beat
  // ---------------------------------------------------------------------------
  class heading_scoreboard;
    logic [ADJ_W-1:0] adj_x;
    logic [ADJ_W-1:0] adj_y;
    int               decl_q12;
    int               peak_x, floor_x, peak_y, floor_y;
    int               ring_x [RING_DEPTH];
    int               ring_y [RING_DEPTH];
    int               sum_x, sum_y;
    int               slot;
    heading_t         pending_headings [$];
    int               errors;
    int               samples;
    int               flagged;
    int               checked;

    function new();
      adj_x    = ADJ_W'(ADJ_RESET);
      adj_y    = ADJ_W'(ADJ_RESET);
      decl_q12 = DECL_RESET;
      peak_x   = AXIS_MIN;
      floor_x  = AXIS_MAX;
      peak_y   = AXIS_MIN;
      floor_y  = AXIS_MAX;
      foreach (ring_x[i]) begin
        ring_x[i] = 0;
        ring_y[i] = 0;
      end
      sum_x   = 0;
      sum_y   = 0;
      slot    = 0;
      errors  = 0;
      samples = 0;
      flagged = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_SENS_X: adj_x = value[ADJ_W-1:0];
        REG_SENS_Y: adj_y = value[ADJ_W-1:0];
        REG_DECL:   decl_q12 = int'(signed'(value[DECL_W-1:0]));
        default:    ;
      endcase
    endfunction

    // negate, apply sensitivity gain, truncate toward zero, saturate
    function int scale_axis(logic signed [RAW_W-1:0] raw, logic [ADJ_W-1:0] adj);
      int v;
      int p;
      v = -int'(raw);
      p = v * (int'(adj) + GAIN_OFS) / 256;
      if (p > AXIS_MAX) p = AXIS_MAX;
      if (p < AXIS_MIN) p = AXIS_MIN;
      return p;
    endfunction

    // vectoring atan2, q16 radians, arithmetic shifts round toward minus infinity
    function longint cordic_angle(int mx, int my);
      longint vx, vy, z, dx, dy;
      int     i;
      vx = longint'(mx) * 256;
      vy = longint'(my) * 256;
      z  = 0;
      if (vx < 0) begin
        z  = (vy >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
        vx = -vx;
        vy = -vy;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy > 0) begin
          vx += dx;
          vy -= dy;
          z  += ARCTAN_Q16[i];
        end else begin
          vx -= dx;
          vy += dy;
          z  -= ARCTAN_Q16[i];
        end
      end
      return z;
    endfunction

    function heading_t predict_heading(int sx, int sy);
      int       ex, ey;
      longint   ang;
      int       deg;
      heading_t h;
      if (sx > peak_x)  peak_x  = sx;
      if (sx < floor_x) floor_x = sx;
      if (sy > peak_y)  peak_y  = sy;
      if (sy < floor_y) floor_y = sy;
      ex = sx - (peak_x + floor_x) / 2;
      ey = sy - (peak_y + floor_y) / 2;
      sum_x += ex - ring_x[slot];
      sum_y += ey - ring_y[slot];
      ring_x[slot] = ex;
      ring_y[slot] = ey;
      slot = (slot + 1) % RING_DEPTH;
      ang = cordic_angle(sum_x / RING_DEPTH, sum_y / RING_DEPTH);
      ang -= longint'(decl_q12) * 16;
      if (ang < 0) ang += TURN_Q16;
      if (ang < 0) ang += TURN_Q16;
      if (ang >= TURN_Q16) ang -= TURN_Q16;
      if (ang >= TURN_Q16) ang -= TURN_Q16;
      deg = int'(ang * DEG_HALF / PI_Q16);
      h.deg = DEG_W'(deg);
      if (deg >= SECTOR_WRAP || deg < SECTOR_LO) h.sector = '0;
      else h.sector = SECTOR_W'((deg - SECTOR_LO) / SECTOR_BAND + 1);
      return h;
    endfunction

    function void note_sample(logic signed [RAW_W-1:0] rx, logic signed [RAW_W-1:0] ry,
                              logic ovr, logic ofl);
      samples++;
      if (ovr || ofl) begin
        flagged++;
        return;
      end
      pending_headings.push_back(predict_heading(scale_axis(rx, adj_x),
                                                 scale_axis(ry, adj_y)));
    endfunction

    function void check_heading(logic [DEG_W-1:0] deg, logic [SECTOR_W-1:0] sector);
      heading_t want;
      if (pending_headings.size() == 0) begin
        $error("unexpected heading beat: heading_deg %0d sector %0d", deg, sector);
        errors++;
        return;
      end
      want = pending_headings.pop_front();
      checked++;
      if (deg !== want.deg) begin
        $error("heading_deg mismatch: expected %0d, actual %0d", want.deg, deg);
        errors++;
      end
      if (sector !== want.sector) begin
        $error("sector mismatch: expected %0d, actual %0d", want.sector, sector);
        errors++;
      end
    endfunction

    function int pending();
      return pending_headings.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block ports, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                       clk                = 1'b0;
  logic                       rst_n              = 1'b0;
  logic                       psel               = 1'b0;
  logic                       penable            = 1'b0;
  logic                       pwrite             = 1'b0;
  logic [PADDR_W-1:0]         paddr              = '0;
  logic [PDATA_W-1:0]         pwdata             = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid           = 1'b0;
  logic                       in_ready;
  logic signed [RAW_W-1:0]    in_raw_x           = '0;
  logic signed [RAW_W-1:0]    in_raw_y           = '0;
  logic                       in_data_overrun    = 1'b0;
  logic                       in_sensor_overflow = 1'b0;
  logic                       out_valid;
  logic                       out_ready          = 1'b0;
  logic [DEG_W-1:0]           out_heading_deg;
  logic [SECTOR_W-1:0]        out_sector;

  heading_scoreboard sb = new();

  // pacing knobs, percent of cycles each side sits idle
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // centre of the "realistic" field cluster, moved per segment
  int field_x = 0;
  int field_y = 0;

  int cycle_count = 0;
  int reg_writes  = 0;
  int seg;

  compass_heading_hard_iron_avg_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_x           (in_raw_x),
    .in_raw_y           (in_raw_y),
    .in_data_overrun    (in_data_overrun),
    .in_sensor_overflow (in_sensor_overflow),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_heading_deg    (out_heading_deg),
    .out_sector         (out_sector)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver backpressure, redrawn every falling edge
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // heading beats are taken at the rising edge, pre-edge values
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_heading(out_heading_deg, out_sector);
  end

  // ---------------------------------------------------------------------------
  // drivers, entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // apb write: setup phase, access phase, done on the edge with pready
  task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one sample beat; idle gaps drop valid only before the payload is shown
  task automatic send_sample(logic signed [RAW_W-1:0] rx, logic signed [RAW_W-1:0] ry,
                             logic ovr, logic ofl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_raw_x           <= rx;
    in_raw_y           <= ry;
    in_data_overrun    <= ovr;
    in_sensor_overflow <= ofl;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(rx, ry, ovr, ofl);
    @(negedge clk);
  endtask

  function automatic logic signed [RAW_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sh7fff;
    endcase
  endfunction

  // mostly clean beats; some full range, some clustered, some extremes, some flagged
  task automatic random_sample();
    int                      kind;
    int                      flags;
    logic signed [RAW_W-1:0] rx;
    logic signed [RAW_W-1:0] ry;
    kind  = $urandom_range(0, 99);
    flags = 0;
    if (kind < 45) begin
      rx = RAW_W'($urandom);
      ry = RAW_W'($urandom);
    end else if (kind < 80) begin
      rx = RAW_W'(field_x + int'($urandom_range(0, 4000)) - 2000);
      ry = RAW_W'(field_y + int'($urandom_range(0, 4000)) - 2000);
    end else if (kind < 90) begin
      rx = pick_extreme();
      ry = pick_extreme();
    end else begin
      // dropped beat, either flag or both
      rx    = RAW_W'($urandom);
      ry    = RAW_W'($urandom);
      flags = $urandom_range(1, 3);
    end
    send_sample(rx, ry, flags[0], flags[1]);
  endtask

  // idle point: valid down, all headings back, then let the front end settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // stray bits above each field, must be ignored
  function automatic logic [PDATA_W-1:0] with_junk(logic [PDATA_W-1:0] v, int width);
    logic [PDATA_W-1:0] mask;
    mask = (PDATA_W'(1) << width) - 1;
    return (PDATA_W'($urandom) & ~mask) | (v & mask);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence: six segments, own register setting each; pairs share one pacing
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (seg = 0; seg < 6; seg++) begin
      // pacing: slow sender / slower receiver, then swapped, then free running
      if (seg < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 84;
      end else if (seg < 4) begin
        send_idle_pct = 84;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      field_x = int'($urandom_range(0, 16000)) - 8000;
      field_y = int'($urandom_range(0, 16000)) - 8000;

      if (seg > 0) begin
        drain();
        case (seg)
          1: begin
            write_reg(REG_SENS_X, with_junk(0, ADJ_W));
            write_reg(REG_SENS_Y, with_junk(0, ADJ_W));
            write_reg(REG_DECL, with_junk(PDATA_W'(-DECL_LIMIT), DECL_W));
          end
          2: begin
            write_reg(REG_SENS_X, with_junk(255, ADJ_W));
            write_reg(REG_SENS_Y, with_junk(255, ADJ_W));
            write_reg(REG_DECL, with_junk(PDATA_W'(DECL_LIMIT), DECL_W));
            // unmapped slot, nothing may change
            write_reg(REG_UNUSED, PDATA_W'($urandom));
          end
          3: begin
            write_reg(REG_SENS_X, with_junk(0, ADJ_W));
            write_reg(REG_SENS_Y, with_junk(255, ADJ_W));
            write_reg(REG_DECL, with_junk(0, DECL_W));
          end
          default: begin
            write_reg(REG_SENS_X, with_junk($urandom_range(0, 255), ADJ_W));
            write_reg(REG_SENS_Y, with_junk($urandom_range(0, 255), ADJ_W));
            write_reg(REG_DECL, with_junk(PDATA_W'(int'($urandom_range(0, 2 * DECL_LIMIT))
                                                   - DECL_LIMIT), DECL_W));
          end
        endcase
      end else begin
        // first clean beat after reset: centre equals sample, zero mean vector
        send_sample(-16'sd1000, 16'sd0, 1'b0, 1'b0);
        // y stays put while x swings: negative x mean with zero y mean, angle +pi
        send_sample(16'sd1000, 16'sd0, 1'b0, 1'b0);
        send_sample(16'sd1000, 16'sd0, 1'b0, 1'b0);
        // dropped beats carrying extreme payloads
        send_sample(16'sh8000, 16'sh8000, 1'b1, 1'b0);
        send_sample(16'sh7fff, 16'sh7fff, 1'b0, 1'b1);
        send_sample(16'sd0, 16'sd0, 1'b1, 1'b1);
        // most negative raw word negates past the top and saturates
        send_sample(16'sh8000, 16'sh8000, 1'b0, 1'b0);
        send_sample(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
        send_sample(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
        send_sample(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_sample(16'sd1, -16'sd1, 1'b0, 1'b0);
        send_sample(-16'sd1, 16'sd1, 1'b0, 1'b0);
        send_sample(16'sh5555, 16'shaaaa, 1'b0, 1'b0);
        send_sample(16'shaaaa, 16'sh5555, 1'b0, 1'b0);
        send_sample(16'sd0, 16'sh8000, 1'b0, 1'b0);
        send_sample(16'sh8000, 16'sd0, 1'b0, 1'b0);
      end

      repeat (RANDOM_PER_SEG) random_sample();
    end

    drain();

    $display("covered %0d sample beats (%0d dropped by flags), %0d register writes",
             sb.samples, sb.flagged, reg_writes);
    $display("six register settings under three pacing modes, %0d headings checked",
             sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
